### design/sfpb_pkg.sv
// shared types, constants and reply tables for the serial flash programmer bridge
package sfpb_pkg;

  localparam int BufBytes = 8192;
  localparam int BufAw    = $clog2(BufBytes);

  localparam logic [7:0] ACK = 8'h06;
  localparam logic [7:0] NAK = 8'h15;

  localparam logic [1:0] CMD_UART = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_SPI  = 2'd2;

  // reply kinds handed from the parser to the sequencer
  localparam logic [3:0] RK_NONE  = 4'd0;
  localparam logic [3:0] RK_ACK   = 4'd1;
  localparam logic [3:0] RK_NAK   = 4'd2;
  localparam logic [3:0] RK_IFACE = 4'd3;
  localparam logic [3:0] RK_MAP   = 4'd4;
  localparam logic [3:0] RK_NAME  = 4'd5;
  localparam logic [3:0] RK_SBUF  = 4'd6;
  localparam logic [3:0] RK_BUS   = 4'd7;
  localparam logic [3:0] RK_WMAX  = 4'd8;
  localparam logic [3:0] RK_SYNC  = 4'd9;
  localparam logic [3:0] RK_RMAX  = 4'd10;
  localparam logic [3:0] RK_FWD   = 4'd11;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  fwd;       // forwarded read byte
    logic        spi;       // one spi byte follows the reply
    logic [BufAw-1:0] idx;  // store address of that spi byte
    logic        wr_phase;  // spi byte comes from the store
    logic        first;
    logic        lst;
  } job_t;

  typedef struct packed {
    logic       port;
    logic [7:0] data;
    logic       spi_first;
    logic       spi_last;
    logic       last;
  } res_t;

  function automatic logic [5:0] reply_len(input logic [3:0] k);
    case (k)
      RK_ACK, RK_NAK, RK_FWD: reply_len = 6'd1;
      RK_BUS, RK_SYNC: reply_len = 6'd2;
      RK_IFACE, RK_SBUF: reply_len = 6'd3;
      RK_WMAX, RK_RMAX: reply_len = 6'd4;
      RK_NAME: reply_len = 6'd17;
      RK_MAP:  reply_len = 6'd33;
      default: reply_len = 6'd0;
    endcase
  endfunction

  function automatic logic [7:0] name_byte(input logic [3:0] i);
    case (i)
      4'd0: name_byte = 8'h46;  4'd1: name_byte = 8'h6C;
      4'd2: name_byte = 8'h61;  4'd3: name_byte = 8'h73;
      4'd4: name_byte = 8'h68;  4'd5: name_byte = 8'h6B;
      4'd6: name_byte = 8'h65;  4'd7: name_byte = 8'h65;
      4'd8: name_byte = 8'h70;  4'd9: name_byte = 8'h65;
      4'd10: name_byte = 8'h72; 4'd11: name_byte = 8'h46;
      4'd12: name_byte = 8'h50; 4'd13: name_byte = 8'h47;
      4'd14: name_byte = 8'h41;
      default: name_byte = 8'h00;
    endcase
  endfunction

  // byte i of a reply, byte 0 being the ack or nak, or the forwarded byte for a forward
  function automatic logic [7:0] reply_byte(input logic [3:0] k, input logic [5:0] i,
                                            input logic [7:0] fwd);
    reply_byte = 8'h00;
    case (k)
      RK_NAK: reply_byte = NAK;
      RK_FWD: reply_byte = fwd;
      RK_SYNC: reply_byte = (i == 6'd0) ? NAK : ACK;
      RK_IFACE: reply_byte = (i == 6'd1) ? 8'h01 : 8'h00;
      RK_SBUF: reply_byte = 8'hFF;
      RK_BUS: reply_byte = 8'h08;
      RK_WMAX: reply_byte = (i == 6'd2) ? 8'h01 : 8'h00;
      RK_RMAX: reply_byte = (i == 6'd2) ? 8'h10 : 8'h00;
      RK_MAP: begin
        case (i)
          6'd1: reply_byte = 8'h3F;
          6'd2: reply_byte = 8'h01;
          6'd3: reply_byte = 8'h0F;
          default: reply_byte = 8'h00;
        endcase
      end
      RK_NAME: reply_byte = name_byte(4'(i - 6'd1));
      default: reply_byte = 8'h00;
    endcase
    if (i == 6'd0 && k != RK_NAK && k != RK_FWD && k != RK_SYNC) reply_byte = ACK;
  endfunction

endpackage

### design/sfpb_parser.sv
// front end: protocol state, header capture and timeout, one job per accepted item
module sfpb_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_in,
  input  logic [7:0]  ferr_count,
  input  logic [31:0] timeout_ticks,
  output logic        job_valid,
  input  logic        job_ready,
  output sfpb_pkg::job_t job,
  output logic        st_we,
  output logic [sfpb_pkg::BufAw-1:0] st_waddr,
  output logic [7:0]  st_wdata
);
  localparam logic [2:0] PH_IDLE = 3'd0, PH_ARG = 3'd1, PH_HDR = 3'd2,
                         PH_WDATA = 3'd3, PH_XCHG = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [23:0] wlen_r, wlen_nxt, rlen_r, rlen_nxt;
  logic [24:0] idx_r, idx_nxt;
  logic [7:0]  fbase_r, fbase_nxt;
  logic [31:0] ticks_r, ticks_nxt;
  sfpb_pkg::job_t j;
  logic [24:0] total, inc, wl, rl;
  logic [32:0] tk;
  logic acc;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign acc = in_valid && job_ready;
  assign job = j;

  always_comb begin
    phase_nxt = phase_r; hcnt_nxt = hcnt_r; wlen_nxt = wlen_r; rlen_nxt = rlen_r;
    idx_nxt = idx_r; fbase_nxt = fbase_r; ticks_nxt = ticks_r;
    j = '0;
    st_we = 1'b0;
    st_waddr = idx_r[sfpb_pkg::BufAw-1:0];
    st_wdata = data_in;
    total = 25'(wlen_r) + 25'(rlen_r);
    inc = idx_r + 25'd1;
    wl = 25'(wlen_r); rl = 25'(rlen_r);
    tk = (ticks_r == 32'hFFFFFFFF) ? {1'b0, ticks_r} : 33'(ticks_r) + 33'd1;
    case (phase_r)
      PH_ARG: begin
        if (cmd == sfpb_pkg::CMD_UART) begin
          j.kind = data_in[3] ? sfpb_pkg::RK_ACK : sfpb_pkg::RK_NAK;
          phase_nxt = PH_IDLE;
        end
      end
      PH_HDR, PH_WDATA: begin
        if (cmd == sfpb_pkg::CMD_UART) begin
          ticks_nxt = '0;
          if (phase_r == PH_HDR) begin
            case (hcnt_r)
              3'd0: wl[7:0] = data_in;
              3'd1: wl[15:8] = data_in;
              3'd2: wl[23:16] = data_in;
              3'd3: rl[7:0] = data_in;
              3'd4: rl[15:8] = data_in;
              default: rl[23:16] = data_in;
            endcase
            wlen_nxt = wl[23:0]; rlen_nxt = rl[23:0];
            hcnt_nxt = hcnt_r + 3'd1;
            total = wl + rl;
            idx_nxt = '0;
            inc = '0;
          end else begin
            st_we = 1'b1;
            idx_nxt = inc;
          end
          if (phase_r == PH_HDR && hcnt_r == 3'd5 && total > 25'(sfpb_pkg::BufBytes)) begin
            phase_nxt = PH_IDLE; j.kind = sfpb_pkg::RK_NAK;
          end else if (phase_r == PH_HDR && hcnt_r == 3'd5 && wl != 25'd0) begin
            phase_nxt = PH_WDATA;
          end else if ((phase_r == PH_HDR && hcnt_r == 3'd5) ||
                       (phase_r == PH_WDATA && inc >= wl)) begin
            idx_nxt = '0;
            if (ferr_count != fbase_r) begin
              phase_nxt = PH_IDLE; j.kind = sfpb_pkg::RK_NAK;
            end else begin
              j.kind = sfpb_pkg::RK_ACK;
              if (total == 25'd0) phase_nxt = PH_IDLE;
              else begin
                phase_nxt = PH_XCHG;
                j.spi = 1'b1; j.first = 1'b1; j.lst = (total == 25'd1);
                j.wr_phase = (wl != 25'd0); j.idx = '0;
              end
            end
          end
        end else if (cmd == sfpb_pkg::CMD_TICK) begin
          ticks_nxt = tk[31:0];
          if (tk[31:0] >= timeout_ticks) begin
            phase_nxt = PH_IDLE; j.kind = sfpb_pkg::RK_NAK;
          end
        end
      end
      PH_XCHG: begin
        if (cmd == sfpb_pkg::CMD_SPI) begin
          if (idx_r >= wl) j.kind = sfpb_pkg::RK_FWD;
          j.fwd = data_in;
          idx_nxt = inc;
          if (inc < total) begin
            j.spi = 1'b1; j.first = 1'b0; j.lst = (inc + 25'd1 == total);
            j.wr_phase = (inc < wl); j.idx = inc[sfpb_pkg::BufAw-1:0];
          end else phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        fbase_nxt = ferr_count;
        if (cmd == sfpb_pkg::CMD_UART) begin
          case (data_in)
            8'h00: j.kind = sfpb_pkg::RK_ACK;
            8'h01: j.kind = sfpb_pkg::RK_IFACE;
            8'h02: j.kind = sfpb_pkg::RK_MAP;
            8'h03: j.kind = sfpb_pkg::RK_NAME;
            8'h04: j.kind = sfpb_pkg::RK_SBUF;
            8'h05: j.kind = sfpb_pkg::RK_BUS;
            8'h08: j.kind = sfpb_pkg::RK_WMAX;
            8'h10: j.kind = sfpb_pkg::RK_SYNC;
            8'h11: j.kind = sfpb_pkg::RK_RMAX;
            8'h12: phase_nxt = PH_ARG;
            8'h13: begin
              phase_nxt = PH_HDR; hcnt_nxt = '0; wlen_nxt = '0; rlen_nxt = '0;
              ticks_nxt = '0;
            end
            default: j.kind = sfpb_pkg::RK_NAK;
          endcase
        end
      end
    endcase
    if (!acc) st_we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; hcnt_r <= '0; wlen_r <= '0; rlen_r <= '0;
      idx_r <= '0; fbase_r <= '0; ticks_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt; hcnt_r <= hcnt_nxt; wlen_r <= wlen_nxt; rlen_r <= rlen_nxt;
      idx_r <= idx_nxt; fbase_r <= fbase_nxt; ticks_r <= ticks_nxt;
    end
  end
endmodule

### design/sfpb_jobq.sv
// two-entry queue of jobs between parser and sequencer
module sfpb_jobq (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  sfpb_pkg::job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output sfpb_pkg::job_t rd_job
);
  sfpb_pkg::job_t mem_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### design/sfpb_seq.sv
// back end: write store and reply sequencer feeding the output register
module sfpb_seq (
  input  logic clk,
  input  logic rst_n,
  input  logic st_we,
  input  logic [sfpb_pkg::BufAw-1:0] st_waddr,
  input  logic [7:0] st_wdata,
  input  logic job_valid,
  output logic job_ready,
  input  sfpb_pkg::job_t job,
  output logic out_valid,
  input  logic out_ready,
  output sfpb_pkg::res_t res
);
  logic [7:0] store_r [sfpb_pkg::BufBytes];
  logic [7:0] rdata_r;
  logic [5:0] pos_r;          // reply byte index, or past it for the spi byte
  logic       busy_r;         // job taken, read launched
  sfpb_pkg::job_t cur_r;
  logic       ov_r;
  sfpb_pkg::res_t ores_r, onxt;
  logic [5:0] rlen;
  logic in_spi, emit, done, take;

  assign rlen = sfpb_pkg::reply_len(cur_r.kind);
  assign in_spi = (pos_r >= rlen);
  assign emit = busy_r && (!ov_r || out_ready);
  assign done = in_spi ? 1'b1 : (pos_r + 6'd1 == rlen && !cur_r.spi);
  assign take = (!busy_r || (emit && done));
  assign job_ready = take;
  assign out_valid = ov_r;
  assign res = ores_r;

  always_comb begin
    onxt = '0;
    if (in_spi) begin
      onxt.port = 1'b1;
      onxt.data = cur_r.wr_phase ? rdata_r : 8'hFF;
      onxt.spi_first = cur_r.first;
      onxt.spi_last = cur_r.lst;
      onxt.last = 1'b1;
    end else begin
      onxt.data = sfpb_pkg::reply_byte(cur_r.kind, pos_r, cur_r.fwd);
      onxt.last = done;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) store_r[st_waddr] <= st_wdata;
    if (take && job_valid) rdata_r <= store_r[job.idx];
    if (emit) ores_r <= onxt;
    if (take && job_valid) cur_r <= job;
    if (!rst_n) begin
      busy_r <= 1'b0; ov_r <= 1'b0; pos_r <= '0;
    end else begin
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (take) begin
        // jobs with no reply and no spi byte just drop
        busy_r <= job_valid && (job.kind != sfpb_pkg::RK_NONE || job.spi);
        pos_r <= '0;
      end else if (emit) pos_r <= pos_r + 6'd1;
    end
  end
endmodule

### design/serial_flash_programmer_bridge_top.sv
// top level of the serial flash programmer bridge
// a request goes through the job queue and the job register to the output register
// throughput: one result byte per cycle while out_tready does not stall the output;
//   an item gives up to 33 result bytes (the command map)
// store reads go through the registered read port of the write store
// reset: synchronous active-low rst_n, timeout reloads to 1200000, phase idle
module serial_flash_programmer_bridge_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  input  logic [15:0] in_tdata,   // data_in[7:0], ferr_count[15:8]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,   // timeout_ticks
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // port[0]
  output logic [15:0] out_tdata,  // data_out[7:0], spi_first[8], spi_last[9], zero pad
  output logic        out_tlast
);
  logic [31:0] tmo_r;
  logic pj_valid, pj_ready, qj_valid, qj_ready, st_we;
  sfpb_pkg::job_t pj, qj;
  sfpb_pkg::res_t res;
  logic [sfpb_pkg::BufAw-1:0] st_waddr;
  logic [7:0] st_wdata;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) tmo_r <= 32'd1200000;
    else if (cfg_valid) tmo_r <= cfg_data;
  end

  // front: classify each request and keep protocol state
  sfpb_parser u_parser (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .cmd(in_tuser), .data_in(in_tdata[7:0]), .ferr_count(in_tdata[15:8]),
    .timeout_ticks(tmo_r), .job_valid(pj_valid), .job_ready(pj_ready), .job(pj),
    .st_we, .st_waddr, .st_wdata
  );

  sfpb_jobq u_q (
    .clk, .rst_n, .wr_valid(pj_valid), .wr_ready(pj_ready), .wr_job(pj),
    .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj)
  );

  // back: play out reply bytes and spi bytes
  sfpb_seq u_seq (
    .clk, .rst_n, .st_we, .st_waddr, .st_wdata,
    .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
    .out_valid(out_tvalid), .out_ready(out_tready), .res
  );

  assign out_tuser = res.port;
  assign out_tdata = {6'd0, res.spi_last, res.spi_first, res.data};
  assign out_tlast = res.last;
endmodule
